// ----- sv/tep_pkg.sv -----
`default_nettype none
package tep_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [15:0] PROB_MIN   = 16'd6554;
  localparam logic [15:0] PROB_MAX   = 16'd65470;
  localparam logic [15:0] PROB_FLOOR = 16'd66;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  localparam logic [1:0] CMD_MEAS  = 2'd0;
  localparam logic [1:0] CMD_MISS  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_TOTAL = 2'd3;

  localparam logic [1:0] REG_DEFAULT = 2'd0;
  localparam logic [1:0] REG_HALF    = 2'd1;
  localparam logic [1:0] REG_TRUE    = 2'd2;
  localparam logic [1:0] REG_FALSE   = 2'd3;

  localparam logic [15:0] RST_DEFAULT = 16'd32768;
  localparam logic [15:0] RST_HALF    = 16'd300;
  localparam logic [15:0] RST_TRUE    = 16'd58982;
  localparam logic [15:0] RST_FALSE   = 16'd13107;

  localparam int DIV_NW = 50;
  localparam int DIV_DW = 34;
  localparam int DIV_CW = $clog2(DIV_NW);

  function automatic logic [31:0] half_pow(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd0:    v = 32'd3037000500;
      4'd1:    v = 32'd3611622603;
      4'd2:    v = 32'd3938502376;
      4'd3:    v = 32'd4112874773;
      4'd4:    v = 32'd4202935003;
      4'd5:    v = 32'd4248701965;
      4'd6:    v = 32'd4271771996;
      4'd7:    v = 32'd4283353945;
      4'd8:    v = 32'd4289156690;
      4'd9:    v = 32'd4292061009;
      4'd10:   v = 32'd4293513907;
      4'd11:   v = 32'd4294240540;
      4'd12:   v = 32'd4294603903;
      4'd13:   v = 32'd4294785595;
      4'd14:   v = 32'd4294876445;
      default: v = 32'd4294921870;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] clamp_prob(input logic [DIV_NW-1:0] p);
    logic [15:0] v;
    if (p < DIV_NW'(PROB_MIN)) v = PROB_MIN;
    else if (p > DIV_NW'(PROB_MAX)) v = PROB_MAX;
    else v = p[15:0];
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tep_div.sv -----
`default_nettype none
module tep_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tep_pkg::DIV_NW-1:0] num,
  input  wire logic [tep_pkg::DIV_DW-1:0] den,
  output logic                           done,
  output logic [tep_pkg::DIV_NW-1:0]     quo,
  output logic [tep_pkg::DIV_DW-1:0]     rem
);

  logic                       busy;
  logic [tep_pkg::DIV_CW-1:0] cnt;
  logic [tep_pkg::DIV_DW-1:0] dreg;
  logic [tep_pkg::DIV_DW:0]   trial;
  logic                       ge;

  assign trial = {rem, quo[tep_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tep_pkg::DIV_CW'(tep_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? tep_pkg::DIV_DW'(trial - {1'b0, dreg}) : trial[tep_pkg::DIV_DW-1:0];
      quo <= {quo[tep_pkg::DIV_NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- sv/tep_ram.sv -----
`default_nettype none
module tep_ram (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [tep_pkg::CH_W-1:0] waddr,
  input  wire logic [15:0]              wdata,
  input  wire logic [tep_pkg::CH_W-1:0] raddr,
  output logic [15:0]                   rdata
);

  logic [15:0]                 mem [tep_pkg::CHANNELS];
  logic [tep_pkg::CHANNELS-1:0] vld;
  logic [15:0]                 rq;
  logic                        rv;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rq <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rv  <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rv <= vld[raddr];
    end
  end

  assign rdata = rv ? rq : tep_pkg::PROB_FLOOR;

endmodule
`default_nettype wire

// ----- sv/track_existence_probability.sv -----
// Existence-probability keeper for one tracked object. Each beat is a
// command (measurement, missed measurement, channel init, total-only update)
// and yields exactly one result beat. Per-channel probabilities live in a
// small single-port-read memory; decays run through a shared 32x32
// multiplier, 16 steps per channel, and Bayes updates and the elapsed-time
// split through one shared bit-serial divider (50 steps a pass). A new result
// beat is held back while an earlier result beat is stalled, and in_stall
// stays high until the new result is registered. One command is in work at
// a time.
`default_nettype none
module track_existence_probability (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  channel,
  input  wire logic [31:0] timestamp_ms,
  input  wire logic [15:0] object_existence,
  input  wire logic        trust_existence,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      total_probability,
  output logic [15:0]      channel_probability,
  output logic [15:0]      missed_run,
  output logic [15:0]      missed_total,
  output logic [15:0]      measured_total,
  output logic             error
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DT      = 5'd1;
  localparam logic [4:0] S_DIVQ_GO = 5'd2;
  localparam logic [4:0] S_DIVQ    = 5'd3;
  localparam logic [4:0] S_DIVF_GO = 5'd4;
  localparam logic [4:0] S_DIVF    = 5'd5;
  localparam logic [4:0] S_RD      = 5'd6;
  localparam logic [4:0] S_RDW     = 5'd7;
  localparam logic [4:0] S_DEC     = 5'd8;
  localparam logic [4:0] S_SHIFT   = 5'd9;
  localparam logic [4:0] S_BMUL    = 5'd10;
  localparam logic [4:0] S_BSUM    = 5'd11;
  localparam logic [4:0] S_BGO     = 5'd12;
  localparam logic [4:0] S_BDIV    = 5'd13;
  localparam logic [4:0] S_NEXT    = 5'd14;
  localparam logic [4:0] S_OUT_RD  = 5'd15;
  localparam logic [4:0] S_OUT_CAP = 5'd16;

  logic [4:0]  state;
  logic [15:0] def_ex, half_ms, true_det, false_det;
  logic [15:0] total, run_cnt, all_cnt, hit_cnt;
  logic [31:0] last_time;

  logic [1:0]  c_cmd;
  logic [5:0]  c_ch;
  logic [31:0] c_t;
  logic [15:0] c_oe;
  logic        c_trust;
  logic        err;

  logic [31:0] dt, q;
  logic [15:0] r, f;
  logic [15:0] tp, pv, tpv;
  logic [31:0] acc, n;
  logic [32:0] m;
  logic [33:0] d;
  logic [3:0]  k;
  logic        on_total;
  logic [tep_pkg::CH_W-1:0] idx;

  logic                       ch_ok;
  logic [15:0]                hl_eff;
  logic                       div_start, div_done;
  logic [tep_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [tep_pkg::DIV_DW-1:0] div_den, div_rem;
  logic                       mem_we;
  logic [tep_pkg::CH_W-1:0]   mem_waddr, mem_raddr;
  logic [15:0]                mem_wdata, mem_rdata;
  logic [63:0]                prod;
  logic [5:0]                 shamt;
  logic [47:0]                rsum, rsh;
  logic [15:0]                dec_res, bay_res, init_val;
  logic [15:0]                e_sel;
  logic [31:0]                tp_full;

  assign ch_ok    = {1'b0, c_ch} < 7'(tep_pkg::CHANNELS);
  assign hl_eff   = (half_ms == 16'd0) ? 16'd1 : half_ms;
  assign in_stall = state != S_IDLE;

  assign e_sel   = c_trust ? c_oe : def_ex;
  assign tp_full = 32'(e_sel) * 32'(true_det) + 32'd32768;

  assign prod  = acc * tep_pkg::half_pow(k);
  assign shamt = 6'(q[4:0]) + 6'd16;
  assign rsum  = {16'b0, acc} + (48'd1 << (shamt - 6'd1));
  assign rsh   = rsum >> shamt;
  always_comb begin
    dec_res = (q < 32'd32) ? rsh[15:0] : 16'd0;
    if (dec_res < tep_pkg::PROB_FLOOR) dec_res = tep_pkg::PROB_FLOOR;
  end

  assign bay_res  = tep_pkg::clamp_prob((d == 34'd0) ? '0 : div_quo);
  assign init_val = tep_pkg::clamp_prob(tep_pkg::DIV_NW'(c_oe));

  always_comb begin
    div_start = 1'b0;
    div_num   = tep_pkg::DIV_NW'(dt);
    div_den   = tep_pkg::DIV_DW'(hl_eff);
    case (state)
      S_DIVQ_GO: div_start = 1'b1;
      S_DIVF_GO: begin
        div_start = 1'b1;
        div_num   = tep_pkg::DIV_NW'({r, 16'b0});
      end
      S_BGO: begin
        div_start = 1'b1;
        div_num   = tep_pkg::DIV_NW'({n, 16'b0}) + tep_pkg::DIV_NW'(d >> 1);
        div_den   = d;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = dec_res;
    mem_raddr = idx;
    case (state)
      S_DT: begin
        mem_we    = (c_cmd == tep_pkg::CMD_INIT) && ch_ok;
        mem_waddr = c_ch[tep_pkg::CH_W-1:0];
        mem_wdata = init_val;
      end
      S_SHIFT: mem_we = !on_total;
      S_BDIV: begin
        mem_we    = div_done && !on_total;
        mem_wdata = bay_res;
      end
      S_OUT_RD, S_OUT_CAP: mem_raddr = c_ch[tep_pkg::CH_W-1:0];
      default: ;
    endcase
  end

  tep_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  tep_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      def_ex    <= tep_pkg::RST_DEFAULT;
      half_ms   <= tep_pkg::RST_HALF;
      true_det  <= tep_pkg::RST_TRUE;
      false_det <= tep_pkg::RST_FALSE;
    end else if (cfg_we) begin
      case (cfg_index)
        tep_pkg::REG_DEFAULT: def_ex    <= cfg_data;
        tep_pkg::REG_HALF:    half_ms   <= cfg_data;
        tep_pkg::REG_TRUE:    true_det  <= cfg_data;
        tep_pkg::REG_FALSE:   false_det <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= tep_pkg::PROB_FLOOR;
      last_time <= '0;
      run_cnt   <= '0;
      all_cnt   <= '0;
      hit_cnt   <= 16'd1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT_CAP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_cmd   <= cmd;
            c_ch    <= channel;
            c_t     <= timestamp_ms;
            c_oe    <= object_existence;
            c_trust <= trust_existence;
            state   <= S_DT;
          end
        end
        S_DT: begin
          err <= 1'b0;
          tp  <= tp_full[31:16];
          idx <= '0;
          case (c_cmd)
            tep_pkg::CMD_MEAS: begin
              if (!ch_ok) begin
                err   <= 1'b1;
                state <= S_OUT_RD;
              end else begin
                dt        <= (c_t >= last_time) ? c_t - last_time : last_time - c_t;
                last_time <= c_t;
                run_cnt   <= '0;
                if (hit_cnt != tep_pkg::CNT_MAX) hit_cnt <= hit_cnt + 16'd1;
                state     <= S_DIVQ_GO;
              end
            end
            tep_pkg::CMD_MISS: begin
              dt <= (c_t >= last_time) ? c_t - last_time : 32'd0;
              if (run_cnt != tep_pkg::CNT_MAX) run_cnt <= run_cnt + 16'd1;
              if (all_cnt != tep_pkg::CNT_MAX) all_cnt <= all_cnt + 16'd1;
              state <= S_DIVQ_GO;
            end
            tep_pkg::CMD_INIT: begin
              if (!ch_ok) begin
                err <= 1'b1;
              end else begin
                total     <= init_val;
                last_time <= c_t;
              end
              state <= S_OUT_RD;
            end
            default: begin
              pv       <= total;
              tpv      <= c_oe;
              on_total <= 1'b1;
              state    <= S_BMUL;
            end
          endcase
        end
        S_DIVQ_GO: state <= S_DIVQ;
        S_DIVQ: begin
          if (div_done) begin
            q     <= div_quo[31:0];
            r     <= div_rem[15:0];
            state <= S_DIVF_GO;
          end
        end
        S_DIVF_GO: state <= S_DIVF;
        S_DIVF: begin
          if (div_done) begin
            f        <= div_quo[15:0];
            on_total <= 1'b0;
            state    <= S_RD;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          pv  <= mem_rdata;
          acc <= {mem_rdata, 16'b0};
          k   <= '0;
          if (c_cmd == tep_pkg::CMD_MEAS && 6'(idx) == c_ch) begin
            tpv   <= true_det;
            state <= S_BMUL;
          end else begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (f[4'd15 - k]) acc <= prod[63:32] + 32'(prod[31]);
          k <= k + 4'd1;
          if (k == 4'd15) state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (on_total) begin
            total <= dec_res;
            state <= S_OUT_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_BMUL: begin
          n     <= pv * tpv;
          m     <= (17'd65536 - 17'(pv)) * false_det;
          state <= S_BSUM;
        end
        S_BSUM: begin
          d     <= 34'(n) + 34'(m);
          state <= S_BGO;
        end
        S_BGO: state <= S_BDIV;
        S_BDIV: begin
          if (div_done) begin
            if (on_total) begin
              total <= bay_res;
              state <= S_OUT_RD;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (idx == tep_pkg::CH_W'(tep_pkg::CHANNELS - 1)) begin
            on_total <= 1'b1;
            pv       <= total;
            tpv      <= tp;
            acc      <= {total, 16'b0};
            k        <= '0;
            state    <= (c_cmd == tep_pkg::CMD_MEAS) ? S_BMUL : S_DEC;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_CAP;
        S_OUT_CAP: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            total_probability   <= total;
            channel_probability <= ch_ok ? mem_rdata : 16'd0;
            missed_run          <= run_cnt;
            missed_total        <= all_cnt;
            measured_total      <= hit_cnt;
            error               <= err;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
